// ===== design/srpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the stepper ramp pulse generator.
// Used by srpg_ctrl, srpg_datapath and the top level; depends on nothing.
package srpg_pkg;

    localparam int STEP_BITS_DEF     = 24;
    localparam int DELAY_BITS_DEF    = 23;
    localparam int POSITION_BITS_DEF = 32;

    localparam int COUNT_W    = 24;
    localparam int COUNT_EXT_W = 32;
    localparam int TOP_W      = 20;
    localparam int RAMP_W     = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_ADDR_W = 1;
    localparam int POS_W      = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam int START_W = 23;
    localparam int SQ_W    = 2 * RAMP_W;
    localparam int PROD_W  = SQ_W + START_W;
    localparam int QUO_W   = START_W;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam logic [START_W-1:0] START_MIN = START_W'(500);
    localparam logic [TOP_W-1:0]   TOP_RESET  = TOP_W'(1000);
    localparam logic [RAMP_W-1:0]  RAMP_RESET = RAMP_W'(10);

    localparam logic [CFG_ADDR_W-1:0] CFG_TOP_SPEED = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAMP      = 1'b1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic take;
        logic mul;
        logic mul2;
        logic div_init;
        logic div_step;
        logic write;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic need_calc;
        logic use_top;
    } t_stat;

endpackage

// ===== design/srpg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: input and output handshakes, delay calculation sequence.
// Depends on srpg_pkg for the command and status structs.
module srpg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_tvalid,
    output logic           o_in_tready,
    input  logic           i_out_tready,
    output logic           o_out_tvalid,
    input  srpg_pkg::t_stat i_stat,
    output srpg_pkg::t_cmd  o_cmd
);
    import srpg_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_MUL2  = 7'b0000100,
        S_DINIT = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_LOAD  = 7'b1000000
    } t_state;

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic                 w_take;

    assign o_in_tready  = (r_state == S_IDLE) && (!r_out_valid || i_out_tready);
    assign w_take       = i_in_tvalid && o_in_tready;
    assign o_out_tvalid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.take    = w_take;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = i_stat.need_calc ? S_MUL : S_LOAD;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_stat.use_top ? S_WRITE : S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DINIT;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.load ? 1'b1 : (r_out_valid && !i_out_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/srpg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: move state, config registers, ramp delay multiply and restoring divide.
// Depends on srpg_pkg; driven by srpg_ctrl commands.
module srpg_datapath #(
    parameter int STEP_BITS     = srpg_pkg::STEP_BITS_DEF,
    parameter int DELAY_BITS    = srpg_pkg::DELAY_BITS_DEF,
    parameter int POSITION_BITS = srpg_pkg::POSITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [srpg_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic [srpg_pkg::IN_TDATA_W-1:0]  i_in_tdata,
    input  logic                             i_in_tuser,
    input  srpg_pkg::t_cmd                   i_cmd,
    output srpg_pkg::t_stat                  o_stat,
    output logic [srpg_pkg::OUT_TDATA_W-1:0] o_out_tdata
);
    import srpg_pkg::*;

    localparam int SUM_W      = ((STEP_BITS > RAMP_W) ? STEP_BITS : RAMP_W) + 1;
    localparam int POS_CALC_W = (POSITION_BITS > STEP_BITS) ? POSITION_BITS : STEP_BITS;
    localparam int SAT_W      = (DELAY_BITS > START_W) ? DELAY_BITS : START_W;
    localparam int POS_EXT_W  = (POSITION_BITS > POS_W) ? POSITION_BITS : POS_W;

    logic [TOP_W-1:0]         r_top;
    logic [RAMP_W-1:0]        r_ramp;

    logic [STEP_BITS-1:0]     r_step_index, n_step_index;
    logic [STEP_BITS-1:0]     r_move_length, n_move_length;
    logic [DELAY_BITS-1:0]    r_hpl, n_hpl;
    logic [DELAY_BITS-1:0]    r_cur_delay;
    logic                     r_high, n_high;
    logic                     r_running, n_running;
    logic                     r_dir, n_dir;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic                     r_done, n_done;

    logic [SQ_W-1:0]          r_kk, r_rr;
    logic [START_W-1:0]       r_start, r_diff;
    logic                     r_use_top;
    logic [PROD_W-1:0]        r_prod;
    logic [SQ_W-1:0]          r_rem;
    logic [QUO_W-1:0]         r_dlo, r_quo;
    logic [OUT_TDATA_W-1:0]   r_out;

    logic [COUNT_EXT_W-1:0]   w_count_ext;
    logic [STEP_BITS-1:0]     w_count, w_idx_next;
    logic                     w_dir, w_end, w_hpl_dec;
    logic [POS_CALC_W-1:0]    w_pos_ext, w_len_ext, w_pos_sum;
    logic [SUM_W-1:0]         w_idx_s, w_len_s, w_ramp_s, w_k_wide;
    logic                     w_accel, w_decel;
    logic                     w_need_calc, w_use_top;
    logic [RAMP_W-1:0]        w_k;
    logic [START_W-1:0]       w_five, w_start, w_val;
    logic [SQ_W:0]            w_trial, w_trial_sub;
    logic                     w_ge;
    logic [SAT_W-1:0]         w_val_ext, w_dmax, w_sat;
    logic [DELAY_BITS-1:0]    w_delay;
    logic [POS_EXT_W-1:0]     w_pos_out;

    assign w_count_ext = COUNT_EXT_W'(i_in_tdata[COUNT_W-1:0]);
    assign w_count     = w_count_ext[STEP_BITS-1:0];
    assign w_dir       = i_in_tdata[COUNT_W];
    assign w_idx_next  = r_step_index + STEP_BITS'(1);
    assign w_end       = (w_idx_next >= r_move_length);
    assign w_hpl_dec   = (r_hpl > DELAY_BITS'(1));

    assign w_pos_ext = POS_CALC_W'(r_pos);
    assign w_len_ext = POS_CALC_W'(r_move_length);
    assign w_pos_sum = r_dir ? (w_pos_ext + w_len_ext) : (w_pos_ext - w_len_ext);

    // Item handling: start, tick countdown, phase flip, step advance
    always_comb begin
        n_step_index  = r_step_index;
        n_move_length = r_move_length;
        n_hpl         = r_hpl;
        n_high        = r_high;
        n_running     = r_running;
        n_dir         = r_dir;
        n_pos         = r_pos;
        n_done        = 1'b0;
        w_need_calc   = 1'b0;
        if (i_in_tuser == OP_START) begin
            if (!r_running) begin
                n_dir         = w_dir;
                n_move_length = w_count;
                n_step_index  = '0;
                if (w_count == '0) begin
                    n_running = 1'b0;
                    n_high    = 1'b0;
                    n_done    = 1'b1;
                end else begin
                    n_running   = 1'b1;
                    w_need_calc = 1'b1;
                end
            end
        end else if (r_running) begin
            if (w_hpl_dec) begin
                n_hpl = r_hpl - DELAY_BITS'(1);
            end else if (r_high) begin
                n_high = 1'b0;
                n_hpl  = r_cur_delay;
            end else begin
                n_step_index = w_idx_next;
                if (w_end) begin
                    n_running = 1'b0;
                    n_high    = 1'b0;
                    n_pos     = w_pos_sum[POSITION_BITS-1:0];
                    n_done    = 1'b1;
                end else begin
                    w_need_calc = 1'b1;
                end
            end
        end
    end

    // Ramp branch selection and start delay
    always_comb begin
        w_idx_s   = SUM_W'(r_step_index);
        w_len_s   = SUM_W'(r_move_length);
        w_ramp_s  = SUM_W'(r_ramp);
        w_accel   = (w_idx_s < w_ramp_s);
        w_decel   = (r_ramp != '0) && ((w_idx_s + w_ramp_s) >= w_len_s);
        w_k_wide  = w_accel ? w_idx_s : (w_len_s - w_idx_s);
        w_k       = w_k_wide[RAMP_W-1:0];
        w_use_top = !w_accel && !w_decel;
        w_five  = START_W'({r_top, 2'b00}) + START_W'(r_top);
        w_start = (w_five < START_MIN) ? START_MIN : w_five;
    end

    assign o_stat = '{need_calc: w_need_calc, use_top: w_use_top};

    assign w_trial     = {r_rem, r_dlo[QUO_W-1]};
    assign w_trial_sub = w_trial - {1'b0, r_rr};
    assign w_ge        = (w_trial >= {1'b0, r_rr});

    always_comb begin
        w_val     = r_use_top ? START_W'(r_top) : (r_start - r_quo);
        w_val_ext = SAT_W'(w_val);
        w_dmax    = SAT_W'({DELAY_BITS{1'b1}});
        w_sat     = (w_val_ext > w_dmax) ? w_dmax : w_val_ext;
        w_delay   = w_sat[DELAY_BITS-1:0];
    end

    assign w_pos_out = POS_EXT_W'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top         <= TOP_RESET;
            r_ramp        <= RAMP_RESET;
            r_step_index  <= '0;
            r_move_length <= '0;
            r_hpl         <= '0;
            r_cur_delay   <= '0;
            r_high        <= 1'b0;
            r_running     <= 1'b0;
            r_dir         <= 1'b0;
            r_pos         <= '0;
            r_done        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TOP_SPEED: r_top  <= i_cfg_wdata[TOP_W-1:0];
                    CFG_RAMP:      r_ramp <= i_cfg_wdata[RAMP_W-1:0];
                    default:       r_top  <= r_top;
                endcase
            end
            if (i_cmd.take) begin
                r_step_index  <= n_step_index;
                r_move_length <= n_move_length;
                r_hpl         <= n_hpl;
                r_high        <= n_high;
                r_running     <= n_running;
                r_dir         <= n_dir;
                r_pos         <= n_pos;
                r_done        <= n_done;
            end
            if (i_cmd.write) begin
                r_cur_delay <= w_delay;
                r_hpl       <= w_delay;
                r_high      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_kk      <= SQ_W'(w_k) * SQ_W'(w_k);
            r_rr      <= SQ_W'(r_ramp) * SQ_W'(r_ramp);
            r_start   <= w_start;
            r_diff    <= w_start - START_W'(r_top);
            r_use_top <= w_use_top;
        end
        if (i_cmd.mul2) begin
            r_prod <= PROD_W'(r_kk) * PROD_W'(r_diff);
        end
        if (i_cmd.div_init) begin
            r_rem <= r_prod[PROD_W-1:QUO_W];
            r_dlo <= r_prod[QUO_W-1:0];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_trial_sub[SQ_W-1:0] : w_trial[SQ_W-1:0];
            r_dlo <= {r_dlo[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
        if (i_cmd.load) begin
            r_out <= {4'b0000, w_pos_out[POS_W-1:0], r_done, r_running,
                      r_dir, r_running && r_high};
        end
    end

    assign o_out_tdata = r_out;

endmodule

// ===== design/stepper_ramp_pulse_generator.sv =====
`timescale 1ns / 1ps
// Stepper pulse generator paced by one-microsecond tick transactions. A tick, an ignored
// start, a zero-step start or the tick that ends a move goes from acceptance straight to
// the load state and its result; a transaction that starts a move or begins a new step
// computes that step's delay: the top-speed delay (cruise or no ramp) is written right after
// the first multiply state, a ramp delay by two registered multiplies and a restoring divider for k*k*(S-T)/(R*R).
// The next transaction is accepted once the controller is idle and the output register
// is free or being drained. Write config only while no transaction is in flight; a new
// value applies from the next step's delay.
module stepper_ramp_pulse_generator #(
    parameter int STEP_BITS     = srpg_pkg::STEP_BITS_DEF,
    parameter int DELAY_BITS    = srpg_pkg::DELAY_BITS_DEF,
    parameter int POSITION_BITS = srpg_pkg::POSITION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [srpg_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [23:0] step_count, [24] direction, [31:25] zero
    input  logic [srpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] step_level, [1] dir_level, [2] busy_res, [3] done_res, [35:4] position,
    // [39:36] zero
    output logic [srpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import srpg_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    srpg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .o_in_tready  (s_axis_tready),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    srpg_datapath #(
        .STEP_BITS     (STEP_BITS),
        .DELAY_BITS    (DELAY_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_tdata (m_axis_tdata)
    );

    a_step_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2])
        else $error("step pin high without a running move");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done reported while still busy");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("transaction accepted while result still pending");

    a_load_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted before result was produced");

endmodule

// ===== sim/step_pulse_checker.sv =====
`timescale 1ns / 1ps
// Checker for the stepper ramp pulse generator: follows every config write and
// every transaction on both stream ports, predicts each status word, compares fields.
// Depends on srpg_pkg for opcodes, register indexes, reset values and bus widths.
module step_pulse_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srpg_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [srpg_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [srpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [srpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output logic                             o_move_active,
    output logic [23:0]                      o_steps_left
);
    import srpg_pkg::*;

    localparam longint unsigned DELAY_CAP = (64'd1 << 23) - 1;

    typedef struct packed {
        logic [31:0] position;
        logic        done;
        logic        busy;
        logic        dir;
        logic        step;
    } pin_status_t;

    logic [TOP_W-1:0]  top_speed_cfg;
    logic [RAMP_W-1:0] ramp_cfg;
    logic [23:0]       step_idx;
    logic [23:0]       move_len;
    logic [22:0]       half_left;
    logic [22:0]       step_delay;
    logic              high_half;
    logic              running;
    logic              move_dir;
    logic [31:0]       position;
    int                errors = 0;
    pin_status_t       status_due_q[$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_move_active = 1'b0;
        o_steps_left  = '0;
    end

    function automatic logic [22:0] ramp_delay(input logic [23:0] idx, input logic [23:0] len);
        longint unsigned top, r, s, d, i, n, q;
        top = top_speed_cfg;
        r   = ramp_cfg;
        i   = idx;
        n   = len;
        s   = top * 5;
        if (s < START_MIN) s = START_MIN;
        d = s - top;
        q = top;
        if (i < r) begin
            q = s - (i * i * d) / (r * r);
        end else if (r != 0 && i + r >= n) begin
            q = s - ((n - i) * (n - i) * d) / (r * r);
        end
        return (q > DELAY_CAP) ? 23'(DELAY_CAP) : 23'(q);
    endfunction

    task automatic close_move();
        running   = 1'b0;
        high_half = 1'b0;
        position  = move_dir ? position + 32'(move_len) : position - 32'(move_len);
    endtask

    task automatic track_item(input logic op, input logic [23:0] count, input logic dir);
        pin_status_t want;
        logic        done;
        done = 1'b0;
        if (op == OP_START) begin
            if (!running) begin
                move_dir = dir;
                move_len = count;
                step_idx = '0;
                if (count == 0) begin
                    close_move();
                    done = 1'b1;
                end else begin
                    running    = 1'b1;
                    step_delay = ramp_delay(24'd0, count);
                    half_left  = step_delay;
                    high_half  = 1'b1;
                end
            end
        end else if (running) begin
            if (half_left > 1) begin
                half_left = half_left - 1'b1;
            end else if (high_half) begin
                high_half = 1'b0;
                half_left = step_delay;
            end else begin
                step_idx = step_idx + 1'b1;
                if (step_idx >= move_len) begin
                    close_move();
                    done = 1'b1;
                end else begin
                    step_delay = ramp_delay(step_idx, move_len);
                    half_left  = step_delay;
                    high_half  = 1'b1;
                end
            end
        end
        want.step     = running && high_half;
        want.dir      = move_dir;
        want.busy     = running;
        want.done     = done;
        want.position = position;
        status_due_q.push_back(want);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_status(input logic [OUT_TDATA_W-1:0] word);
        pin_status_t want;
        pin_status_t got;
        got = pin_status_t'(word[35:0]);
        if (status_due_q.size() == 0) begin
            $display("%0t: status transaction with nothing outstanding, expected none, actual %h",
                     $time, word);
            errors++;
        end else begin
            want = status_due_q.pop_front();
            compare_field("step_level", 32'(want.step), 32'(got.step));
            compare_field("dir_level", 32'(want.dir), 32'(got.dir));
            compare_field("busy", 32'(want.busy), 32'(got.busy));
            compare_field("done", 32'(want.done), 32'(got.done));
            compare_field("position", want.position, got.position);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            top_speed_cfg = TOP_RESET;
            ramp_cfg      = RAMP_RESET;
            step_idx      = '0;
            move_len      = '0;
            half_left     = '0;
            step_delay    = '0;
            high_half     = 1'b0;
            running       = 1'b0;
            move_dir      = 1'b0;
            position      = '0;
            status_due_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TOP_SPEED: top_speed_cfg = i_cfg_wdata[TOP_W-1:0];
                    CFG_RAMP:      ramp_cfg = i_cfg_wdata[RAMP_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                track_item(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[24]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_status(m_axis_tdata);
            end
        end
        o_fail_count  <= errors;
        o_pending     <= status_due_q.size();
        o_move_active <= running;
        o_steps_left  <= move_len - step_idx;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the stepper ramp pulse generator: clock, reset, config writes,
// tick and start traffic with random idling. Relies on step_pulse_checker and srpg_pkg.
module tb_top;
    import srpg_pkg::*;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;

    int          fail_count;
    int          pending;
    logic        move_active;
    logic [23:0] steps_left;
    bit          calm = 1'b0;
    int          item_total = 0;

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 15);
    end

    stepper_ramp_pulse_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    step_pulse_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_move_active (move_active),
        .o_steps_left  (steps_left)
    );

    initial begin
        #5_000_000;
        $display("FAIL stepper_ramp_pulse_generator");
        $finish;
    end

    task automatic issue_command(input logic op, input logic [23:0] count, input logic dir);
        int roll;
        roll = $urandom_range(0, 99);
        if (!calm && roll < 2) begin
            // hold off until every status transaction is back
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
        end else if (!calm && roll < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({dir, count});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        item_total++;
    endtask

    // move_active and steps_left trail by one transaction; send a stray start only
    // when the move cannot end before it lands
    task automatic drive_move(input logic [23:0] count, input logic dir);
        issue_command(OP_START, count, dir);
        do begin
            if (move_active && steps_left >= 2 && $urandom_range(0, 99) < 8)
                issue_command(OP_START, 24'($urandom), 1'($urandom));
            else
                issue_command(OP_TICK, 24'($urandom), 1'($urandom));
        end while (move_active);
    endtask

    task automatic drain_to_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || move_active) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    // hold the input until every status transaction is back; the move may go on
    task automatic settle_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic load_profile(input logic [TOP_W-1:0] top, input logic [RAMP_W-1:0] ramp);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TOP_SPEED;
        i_cfg_wdata <= CFG_W'(top);
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RAMP;
        i_cfg_wdata <= CFG_W'(ramp);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // switch the ramp length between transactions of a running move, then tick on
    task automatic ramp_window(input logic [RAMP_W-1:0] ramp, input logic [23:0] until_left);
        settle_results();
        load_profile(20'd0, ramp);
        while (steps_left > until_left) issue_command(OP_TICK, 24'd0, 1'b0);
    endtask

    task automatic random_traffic(input int target);
        int stop_at;
        int roll;
        stop_at = item_total + target;
        while (item_total < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                issue_command(OP_TICK, 24'($urandom), 1'($urandom));
            else if (roll < 15)
                issue_command(OP_START, 24'd0, 1'($urandom));
            else if (roll < 25)
                drive_move(24'($urandom_range(7, 40)), 1'($urandom));
            else
                drive_move(24'($urandom_range(1, 6)), 1'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset profile: idle ticks and zero-length moves only
        issue_command(OP_TICK, 24'hFFFFFF, 1'b1);
        issue_command(OP_START, 24'd0, 1'b1);
        issue_command(OP_START, 24'd0, 1'b0);
        issue_command(OP_TICK, 24'd0, 1'b0);
        issue_command(OP_START, 24'd0, 1'b1);
        drain_to_idle();

        // zero delay, no ramp; start while busy must be dropped
        load_profile(20'd0, 16'd0);
        issue_command(OP_START, 24'd3, 1'b0);
        issue_command(OP_START, 24'hFFFFFF, 1'b1);
        do issue_command(OP_TICK, 24'd0, 1'b0); while (move_active);
        drive_move(24'd1, 1'b1);
        drive_move(24'd2, 1'b1);
        drain_to_idle();

        // long move at zero top-speed delay: cruise under a short ramp, then a long ramp
        // where acceleration wins over the overlapping deceleration, then deceleration
        load_profile(20'd0, 16'd0);
        issue_command(OP_START, 24'd200, 1'b1);
        do issue_command(OP_TICK, 24'd0, 1'b0); while (steps_left > 24'd190);
        ramp_window(16'd5, 24'd102);
        ramp_window(16'd101, 24'd98);
        settle_results();
        load_profile(20'd0, 16'd0);
        do issue_command(OP_TICK, 24'd0, 1'b0); while (move_active);
        drain_to_idle();

        load_profile(20'hFFFFF, 16'hFFFF);
        issue_command(OP_TICK, 24'h555555, 1'b0);
        issue_command(OP_START, 24'd0, 1'b1);
        issue_command(OP_START, 24'd0, 1'b0);
        issue_command(OP_TICK, 24'hAAAAAA, 1'b1);
        drain_to_idle();

        for (int p = 0; p < 6; p++) begin
            load_profile((p == 5) ? 20'($urandom_range(5, 12)) : 20'($urandom_range(0, 4)),
                         16'd0);
            calm = (p == 2);
            random_traffic(80);
            drain_to_idle();
        end
        calm = 1'b0;

        if (fail_count == 0 && pending == 0)
            $display("PASS stepper_ramp_pulse_generator");
        else
            $display("FAIL stepper_ramp_pulse_generator");
        $finish;
    end

endmodule
